// ===== rtl/core/iirdb_pkg.sv =====
// Shared constants and types for the deadband IIR filter core.
// Standalone package; imported by iir_filter_with_deadband_top.
`default_nettype none

package iirdb_pkg;

    // Fixed data widths
    localparam int SAMPLE_BITS     = 16;
    localparam int COEFF_BITS      = 16;
    localparam int COEFF_FRAC_BITS = 14;
    localparam int MAX_TAPS        = 4;
    localparam int DEPTH           = 4;
    localparam int TAP_W           = 3;
    localparam int DEADBAND_W      = 15;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_IDX_W       = 3;

    // Accumulator: 8 products of 16x16 plus growth and rounding headroom
    localparam int PROD_W = SAMPLE_BITS + COEFF_BITS;
    localparam int ACC_W  = PROD_W + 4;
    // Width of the rounded sum before clipping
    localparam int RES_W  = ACC_W - COEFF_FRAC_BITS;

    // Step counter covers feedforward then feedback tap slots
    localparam int STEP_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEFF_01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEFF_23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FF_TAPS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FB_TAPS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd6;

    // Reset values
    localparam logic [CFG_DATA_W-1:0] COEFF_PAIR_ONE = 32'h4000_4000;
    localparam logic [TAP_W-1:0]      FF_TAPS_RST    = 3'd4;
    localparam logic [TAP_W-1:0]      FB_TAPS_RST    = 3'd0;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RST   = 15'd4;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [ACC_W-1:0]       t_acc;

endpackage

`default_nettype wire

// ===== rtl/core/iir_filter_with_deadband_top.sv =====
// Direct form I IIR filter with output deadband, one axis, signed Q4.12.
// Uses iirdb_pkg for widths, register indexes and reset values.
// One shared 16x16 multiply-accumulate walks four feedforward then four
// feedback tap slots, one slot per cycle, then the result enters the output
// register once that register is free; no new request is accepted before then.
// A finished result waits in the output register while the next request runs.
// Reset (synchronous, active low): coefficients 1.0, ff_taps 4, fb_taps 0,
// deadband 4, both histories zero, no result pending.
`default_nettype none

module iir_filter_with_deadband_top
    import iirdb_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Input stream
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire [15:0]             i_s_axis_tdata,   // [15:0] sample
    // Output stream
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    output logic [15:0]            o_m_axis_tdata,   // [15:0] filtered
    output logic                   o_m_axis_tuser,   // [0] saturated
    // Configuration writes
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [STEP_W-1:0] STEP_LAST = {STEP_W{1'b1}};
    localparam logic [TAP_W-1:0]  TAP_LIM   = TAP_W'(MAX_TAPS < DEPTH ? MAX_TAPS : DEPTH);
    localparam t_acc              ROUND_HALF = t_acc'(1) <<< (COEFF_FRAC_BITS - 1);
    localparam logic signed [RES_W-1:0] SMAX = RES_W'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RES_W-1:0] SMIN = -SMAX - RES_W'(1);

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_ff01, r_ff23, r_fb01, r_fb23;
    logic [TAP_W-1:0]      r_ff_taps, r_fb_taps;
    logic [DEADBAND_W-1:0] r_deadband;

    // Histories, entry 0 newest
    t_sample r_in_hist  [DEPTH];
    t_sample r_out_hist [DEPTH];

    // Sequencer and datapath
    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_acc              r_acc, n_acc;

    // Output register
    logic              r_out_valid;
    logic [15:0]       r_out_data;
    logic              r_out_sat;

    logic cfg_wr, cfg_hit, in_acc, out_load;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_sat;

    assign cfg_wr  = i_cfg_valid & o_cfg_ready;
    assign cfg_hit = cfg_wr && (i_cfg_index <= REG_DEADBAND);
    assign in_acc  = i_s_axis_tvalid & o_s_axis_tready;

    // Clamp tap counts to the history depth
    logic [TAP_W-1:0] ff_cnt, fb_cnt;
    assign ff_cnt = (r_ff_taps > TAP_LIM) ? TAP_LIM : r_ff_taps;
    assign fb_cnt = (r_fb_taps > TAP_LIM) ? TAP_LIM : r_fb_taps;

    // Select operands for the current tap slot
    logic [1:0]            tap;
    logic                  is_fb;
    t_sample               hist_op;
    logic [CFG_DATA_W-1:0] coeff_word;
    logic signed [COEFF_BITS-1:0] coeff_op;
    logic                  tap_on;
    logic signed [PROD_W-1:0] prod;
    t_acc                  prod_ext;

    assign tap        = r_step[1:0];
    assign is_fb      = r_step[2];
    assign hist_op    = is_fb ? r_out_hist[tap] : r_in_hist[tap];
    assign coeff_word = is_fb ? (tap[1] ? r_fb23 : r_fb01) : (tap[1] ? r_ff23 : r_ff01);
    assign coeff_op   = tap[0] ? coeff_word[31:16] : coeff_word[15:0];
    assign tap_on     = ({1'b0, tap} < (is_fb ? fb_cnt : ff_cnt));
    assign prod       = hist_op * coeff_op;
    assign prod_ext   = t_acc'(prod);

    // Round half up, floor shift, clip, deadband
    t_acc                   rounded;
    logic signed [RES_W-1:0] res_wide;
    logic                   sat_hi, sat_lo;
    t_sample                clipped;
    logic signed [SAMPLE_BITS:0] clip_ext, mag;
    logic                   keep;
    t_sample                final_val;

    assign rounded   = r_acc + ROUND_HALF;
    assign res_wide  = RES_W'(rounded >>> COEFF_FRAC_BITS);
    assign sat_hi    = res_wide > SMAX;
    assign sat_lo    = res_wide < SMIN;
    assign clipped   = sat_hi ? SAMPLE_BITS'(SMAX) :
                       sat_lo ? SAMPLE_BITS'(SMIN) : SAMPLE_BITS'(res_wide);
    assign clip_ext  = (SAMPLE_BITS + 1)'(clipped);
    assign mag       = clip_ext[SAMPLE_BITS] ? -clip_ext : clip_ext;
    assign keep      = mag >= $signed({2'b00, r_deadband});
    assign final_val = keep ? clipped : '0;

    assign out_load  = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_acc   = r_acc;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_MAC;
                    n_step  = '0;
                    n_acc   = '0;
                end
            end
            S_MAC: begin
                if (tap_on) begin
                    n_acc = is_fb ? (r_acc - prod_ext) : (r_acc + prod_ext);
                end
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_acc   <= n_acc;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff01     <= COEFF_PAIR_ONE;
            r_ff23     <= COEFF_PAIR_ONE;
            r_fb01     <= COEFF_PAIR_ONE;
            r_fb23     <= COEFF_PAIR_ONE;
            r_ff_taps  <= FF_TAPS_RST;
            r_fb_taps  <= FB_TAPS_RST;
            r_deadband <= DEADBAND_RST;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_FF_COEFF_01: r_ff01     <= i_cfg_data;
                REG_FF_COEFF_23: r_ff23     <= i_cfg_data;
                REG_FB_COEFF_01: r_fb01     <= i_cfg_data;
                REG_FB_COEFF_23: r_fb23     <= i_cfg_data;
                REG_FF_TAPS:     r_ff_taps  <= i_cfg_data[TAP_W-1:0];
                REG_FB_TAPS:     r_fb_taps  <= i_cfg_data[TAP_W-1:0];
                REG_DEADBAND:    r_deadband <= i_cfg_data[DEADBAND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Histories: clear on reset or a write to a defined register, shift on accept and on result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_in_hist[i]  <= '0;
                r_out_hist[i] <= '0;
            end
        end else begin
            if (in_acc) begin
                for (int i = DEPTH - 1; i > 0; i--) begin
                    r_in_hist[i] <= r_in_hist[i-1];
                end
                r_in_hist[0] <= $signed(i_s_axis_tdata);
            end
            if (out_load) begin
                for (int i = DEPTH - 1; i > 0; i--) begin
                    r_out_hist[i] <= r_out_hist[i-1];
                end
                r_out_hist[0] <= final_val;
            end
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= final_val;
            r_out_sat  <= sat_hi | sat_lo;
        end
    end

    // Checks
    a_accept_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_MAC) && (r_step == '0))
        else $error("accepted request did not start the tap walk");

    a_walk_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) && (r_step == STEP_LAST) |=> (r_state == S_DONE))
        else $error("tap walk did not end in result stage");

    a_sat_is_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |->
            (r_out_data == 16'h7FFF) || (r_out_data == 16'h8000))
        else $error("saturated result is not a range limit");

    a_cfg_clears_hist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_in_hist[0] == '0) && (r_out_hist[0] == '0))
        else $error("register write did not clear histories");

endmodule

`default_nettype wire

// ===== tb/iirdb_checker.sv =====
// Checker for the deadband IIR filter: watches the sample, result and register
// channels, predicts every result and compares it field by field.
// Depends on iirdb_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module iirdb_checker
    import iirdb_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    input  wire                  i_s_tready,
    input  wire [15:0]           i_s_tdata,
    input  wire                  i_m_tvalid,
    input  wire                  i_m_tready,
    input  wire [15:0]           i_m_tdata,
    input  wire                  i_m_tuser,
    input  wire                  i_cfg_valid,
    input  wire                  i_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam longint SUM_MAX = 32767;
    localparam longint SUM_MIN = -32768;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] filtered;
        logic                   saturated;
    } t_filter_out;

    // Predicted filter outputs, oldest first
    t_filter_out expected_outputs[$];

    logic signed [COEFF_BITS-1:0] ff_coeff [MAX_TAPS];
    logic signed [COEFF_BITS-1:0] fb_coeff [MAX_TAPS];
    logic [TAP_W-1:0]             ff_taps_reg;
    logic [TAP_W-1:0]             fb_taps_reg;
    logic [DEADBAND_W-1:0]        deadband_reg;
    t_sample                      x_hist [DEPTH];
    t_sample                      y_hist [DEPTH];

    function automatic void clear_histories();
        for (int i = 0; i < DEPTH; i++) begin
            x_hist[i] = '0;
            y_hist[i] = '0;
        end
    endfunction

    function automatic int used_taps(input logic [TAP_W-1:0] n);
        return (n > MAX_TAPS) ? MAX_TAPS : int'(n);
    endfunction

    // Mirror a register write; any listed register also wipes both histories
    function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_FF_COEFF_01: begin
                ff_coeff[0] = d[15:0];
                ff_coeff[1] = d[31:16];
            end
            REG_FF_COEFF_23: begin
                ff_coeff[2] = d[15:0];
                ff_coeff[3] = d[31:16];
            end
            REG_FB_COEFF_01: begin
                fb_coeff[0] = d[15:0];
                fb_coeff[1] = d[31:16];
            end
            REG_FB_COEFF_23: begin
                fb_coeff[2] = d[15:0];
                fb_coeff[3] = d[31:16];
            end
            REG_FF_TAPS:  ff_taps_reg  = d[TAP_W-1:0];
            REG_FB_TAPS:  fb_taps_reg  = d[TAP_W-1:0];
            REG_DEADBAND: deadband_reg = d[DEADBAND_W-1:0];
            default: return;
        endcase
        clear_histories();
    endfunction

    // Shift in one sample, form the exact sum, round, clip, apply the deadband
    function automatic t_filter_out filter_sample(input t_sample s);
        longint      acc;
        longint      r;
        longint      mag;
        int          nff;
        int          nfb;
        t_filter_out res;
        nff = used_taps(ff_taps_reg);
        nfb = used_taps(fb_taps_reg);
        for (int i = DEPTH - 1; i > 0; i--)
            x_hist[i] = x_hist[i-1];
        x_hist[0] = s;
        acc = 0;
        for (int i = 0; i < nff; i++)
            acc += longint'(x_hist[i]) * longint'(ff_coeff[i]);
        for (int i = 0; i < nfb; i++)
            acc -= longint'(y_hist[i]) * longint'(fb_coeff[i]);
        // Half an LSB then floor: exact halves go toward plus infinity
        acc += longint'(1) << (COEFF_FRAC_BITS - 1);
        r = acc >>> COEFF_FRAC_BITS;
        res.saturated = 1'b0;
        if (r > SUM_MAX) begin
            r = SUM_MAX;
            res.saturated = 1'b1;
        end else if (r < SUM_MIN) begin
            r = SUM_MIN;
            res.saturated = 1'b1;
        end
        mag = (r < 0) ? -r : r;
        if (mag < longint'(deadband_reg))
            r = 0;
        for (int i = DEPTH - 1; i > 0; i--)
            y_hist[i] = y_hist[i-1];
        y_hist[0] = t_sample'(r[SAMPLE_BITS-1:0]);
        res.filtered = r[SAMPLE_BITS-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_filter_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                ff_coeff[i] = COEFF_PAIR_ONE[15:0];
                fb_coeff[i] = COEFF_PAIR_ONE[15:0];
            end
            ff_taps_reg  = FF_TAPS_RST;
            fb_taps_reg  = FB_TAPS_RST;
            deadband_reg = DEADBAND_RST;
            clear_histories();
            expected_outputs.delete();
            o_fail_count = 0;
        end else begin
            // Compare an accepted result with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                if (expected_outputs.size() == 0) begin
                    $display("%0t: unexpected result filtered=%h saturated=%b",
                             $time, i_m_tdata, i_m_tuser);
                    o_fail_count++;
                end else begin
                    want = expected_outputs.pop_front();
                    if (i_m_tdata !== want.filtered) begin
                        $display("%0t: filtered mismatch, expected %h, actual %h",
                                 $time, want.filtered, i_m_tdata);
                        o_fail_count++;
                    end
                    if (i_m_tuser !== want.saturated) begin
                        $display("%0t: saturated mismatch, expected %b, actual %b",
                                 $time, want.saturated, i_m_tuser);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                apply_write(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && i_s_tready)
                expected_outputs.push_back(filter_sample(t_sample'(i_s_tdata)));
        end
        o_pending = expected_outputs.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the deadband IIR filter testbench: clock, reset, sample and register
// requests, receiver back-pressure, watchdog and verdict.
// Depends on iirdb_pkg, iir_filter_with_deadband_top and iirdb_checker.
`timescale 1ns / 1ps

module testbench;
    import iirdb_pkg::*;

    localparam int                   WATCHDOG_LIMIT = 3000;
    localparam int                   HOLD_CYCLES    = 300;
    localparam int                   DRAIN_CYCLES   = 20;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 3'd7;
    localparam t_sample              SAMPLE_MAX     = 16'sh7FFF;
    localparam t_sample              SAMPLE_MIN     = 16'sh8000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [15:0]           i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [15:0]           o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int idle_cycles;
    bit hold_request;

    iir_filter_with_deadband_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    iirdb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tuser    (o_m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one sample request after a random gap; return once it is accepted
    task automatic send_sample(input t_sample s);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
    endtask

    // Stop offering and hold until every predicted result has come back
    task automatic pause_sender();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        i_cfg_valid     <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // Write one register once the filter has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending != 0) begin
            i_cfg_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_coeff();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(16'h2000));
            2: return 16'(-int'($urandom_range(16'h2000)));
            default: begin
                case ($urandom_range(4))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'h4000;
                    default: return 16'hC000;
                endcase
            end
        endcase
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(3))
            0, 1: return t_sample'($urandom);
            2: return t_sample'(int'($urandom_range(512)) - 256);
            default: begin
                case ($urandom_range(3))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return '0;
                    default: return -16'sd1;
                endcase
            end
        endcase
    endfunction

    // Load a random setting into every register, sometimes poke the unused index
    task automatic random_setup();
        logic [DEADBAND_W-1:0] db;
        case ($urandom_range(7))
            0:       db = '0;
            5:       db = DEADBAND_W'($urandom);
            6:       db = '1;
            7:       db = DEADBAND_RST;
            default: db = DEADBAND_W'($urandom_range(64));
        endcase
        write_reg(REG_FF_COEFF_01, {pick_coeff(), pick_coeff()});
        write_reg(REG_FF_COEFF_23, {pick_coeff(), pick_coeff()});
        write_reg(REG_FB_COEFF_01, {pick_coeff(), pick_coeff()});
        write_reg(REG_FB_COEFF_23, {pick_coeff(), pick_coeff()});
        write_reg(REG_FF_TAPS, CFG_DATA_W'($urandom_range(7)));
        write_reg(REG_FB_TAPS, CFG_DATA_W'($urandom_range(7)));
        write_reg(REG_DEADBAND, CFG_DATA_W'(db));
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, $urandom);
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        hold_request    = 1'b0;
        hold_left       = 0;
        idle_cycles     = 0;
        send_idle_pct   = 19;
        recv_idle_pct   = 60;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset setting: four unit taps, no feedback, deadband 4.
        // Drive both clip rails, then probe the deadband edge.
        repeat (4) send_sample(SAMPLE_MAX);
        // Unused index must leave the histories alone
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        repeat (4) send_sample(SAMPLE_MIN);
        repeat (4) send_sample('0);
        send_sample(16'sd3);
        send_sample(16'sd1);
        send_sample(-16'sd8);

        // Single half-weight tap, no deadband: exact halves round upward
        write_reg(REG_FF_COEFF_01, 32'h0000_2000);
        write_reg(REG_FF_TAPS, 32'd1);
        write_reg(REG_DEADBAND, 32'd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd3);

        // Extreme weights, tap counts above the limit, widest deadband
        write_reg(REG_FF_COEFF_01, 32'h8000_8000);
        write_reg(REG_FF_COEFF_23, 32'h8000_8000);
        write_reg(REG_FB_COEFF_01, 32'h7FFF_7FFF);
        write_reg(REG_FB_COEFF_23, 32'h7FFF_7FFF);
        write_reg(REG_FF_TAPS, 32'd7);
        write_reg(REG_FB_TAPS, 32'd7);
        write_reg(REG_DEADBAND, 32'h7FFF);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd1);

        // No feedforward terms: output is only the negated feedback
        write_reg(REG_FF_TAPS, 32'd0);
        write_reg(REG_FB_TAPS, 32'd1);
        write_reg(REG_FB_COEFF_01, 32'h0000_C000);
        write_reg(REG_DEADBAND, 32'd0);
        send_sample(SAMPLE_MAX);
        send_sample(-16'sd5);

        // Random part in three back-pressure phases
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 19;
                    recv_idle_pct = 60;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 19;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 4; blk++) begin
                random_setup();
                if (phase == 2 && blk == 1)
                    hold_request = 1'b1;
                for (int n = 0; n < 50; n++) begin
                    send_sample(pick_sample());
                    if (blk == 2 && n == 25)
                        pause_sender();
                end
            end
        end

        // Drain, then give the pipeline time to show any stray result
        pause_sender();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
